@@ rtl/core/i2a_pkg.sv @@
package i2a_pkg;

	// Field sizes
	localparam int VALUE_W    = 64;
	localparam int DIGIT_W    = 4;
	localparam int NUM_DIGITS = 20;
	localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
	localparam int NDIG_W     = 5;
	localparam int CNT_W      = 6;

	// Width saturation limit
	localparam logic [5:0] MAX_WIDTH = 6'd40;

	// Radix modes
	localparam logic [1:0] MODE_DEC   = 2'd0;
	localparam logic [1:0] MODE_LOWER = 2'd1;
	localparam logic [1:0] MODE_UPPER = 2'd2;

	// ASCII codes
	localparam logic [7:0] CHAR_ZERO   = 8'h30;
	localparam logic [7:0] CHAR_SPACE  = 8'h20;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;

	// Normalized digit string: most significant digit in the top nibble
	typedef struct packed {
		logic [BCD_W-1:0]  digits;
		logic [NDIG_W-1:0] ndig;
	} digits_t;

	// Per-transaction emit settings
	typedef struct packed {
		logic [7:0] pad_char;
		logic       upper;
		logic [5:0] width_sat;
		logic [5:0] room;
	} emit_params_t;

	// Digit value to ASCII, 0-9 then a-f or A-F
	function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d, input logic upper);
		logic [7:0] base;
		logic [7:0] ext;
		ext = {4'd0, d};
		base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
		if (d < 4'd10) begin
			digit_char = CHAR_ZERO + ext;
		end else begin
			digit_char = base + ext - 8'd10;
		end
	endfunction

endpackage

@@ rtl/core/i2a_conv.sv @@
module i2a_conv (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [i2a_pkg::VALUE_W-1:0]       value,
	input  logic                              hex,
	output logic                              done,
	output i2a_pkg::digits_t                  result
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_DABBLE = 2'd1;
	localparam logic [1:0] ST_NORM   = 2'd2;

	localparam logic [i2a_pkg::CNT_W-1:0]  LAST_BIT = i2a_pkg::CNT_W'(i2a_pkg::VALUE_W - 1);
	localparam logic [i2a_pkg::NDIG_W-1:0] FULL_NDIG = i2a_pkg::NDIG_W'(i2a_pkg::NUM_DIGITS);
	localparam int TOP = i2a_pkg::BCD_W - i2a_pkg::DIGIT_W;

	logic [1:0]                        state_q;
	logic [i2a_pkg::CNT_W-1:0]         cnt_q;
	logic [i2a_pkg::NDIG_W-1:0]        ndig_q;
	logic                              done_q;
	logic [i2a_pkg::VALUE_W-1:0]       val_q;
	logic [i2a_pkg::BCD_W-1:0]         bcd_q;
	logic [i2a_pkg::BCD_W-1:0]         adj;
	logic                              norm_shift;

	// Double-dabble correction: add 3 to every digit of 5 or more
	always_comb begin
		for (int i = 0; i < i2a_pkg::NUM_DIGITS; i++) begin
			if (bcd_q[i*i2a_pkg::DIGIT_W +: i2a_pkg::DIGIT_W] >= 4'd5) begin
				adj[i*i2a_pkg::DIGIT_W +: i2a_pkg::DIGIT_W] =
					bcd_q[i*i2a_pkg::DIGIT_W +: i2a_pkg::DIGIT_W] + 4'd3;
			end else begin
				adj[i*i2a_pkg::DIGIT_W +: i2a_pkg::DIGIT_W] =
					bcd_q[i*i2a_pkg::DIGIT_W +: i2a_pkg::DIGIT_W];
			end
		end
	end

	// Strip one leading zero digit per cycle, keep at least one digit
	assign norm_shift = (ndig_q > 5'd1) && (bcd_q[TOP +: i2a_pkg::DIGIT_W] == '0);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			ndig_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= hex ? ST_NORM : ST_DABBLE;
						cnt_q   <= '0;
						ndig_q  <= FULL_NDIG;
					end
				end
				ST_DABBLE: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_BIT) begin
						state_q <= ST_NORM;
					end
				end
				ST_NORM: begin
					if (norm_shift) begin
						ndig_q <= ndig_q - 1'b1;
					end else begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Digit shift register: one value bit per cycle in decimal, nibbles load directly in hex
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			val_q <= value;
			bcd_q <= hex ? {{(i2a_pkg::BCD_W - i2a_pkg::VALUE_W){1'b0}}, value} : '0;
		end else if (state_q == ST_DABBLE) begin
			val_q <= {val_q[i2a_pkg::VALUE_W-2:0], 1'b0};
			bcd_q <= {adj[i2a_pkg::BCD_W-2:0], val_q[i2a_pkg::VALUE_W-1]};
		end else if (state_q == ST_NORM && norm_shift) begin
			bcd_q <= {bcd_q[TOP-1:0], {i2a_pkg::DIGIT_W{1'b0}}};
		end
	end

	assign done          = done_q;
	assign result.digits = bcd_q;
	assign result.ndig   = ndig_q;

endmodule

@@ rtl/core/i2a_emit.sv @@
module i2a_emit (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  i2a_pkg::emit_params_t    params,
	input  i2a_pkg::digits_t         digs,
	output logic                     busy,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [7:0]               character,
	output logic                     last_of_run
);

	localparam int TOP = i2a_pkg::BCD_W - i2a_pkg::DIGIT_W;

	logic                          busy_q;
	logic [5:0]                    pad_q;
	logic [i2a_pkg::NDIG_W-1:0]    dig_q;
	logic [5:0]                    rem_q;
	logic [i2a_pkg::BCD_W-1:0]     sh_q;
	logic [7:0]                    padch_q;
	logic                          upper_q;
	logic                          ovalid_q;
	logic [7:0]                    char_q;
	logic                          last_q;

	logic [5:0] ndig_ext;
	logic [5:0] npad;
	logic       take;
	logic       last_c;
	logic [7:0] char_c;

	// Pad count from saturated width and digit count
	assign ndig_ext = {1'b0, digs.ndig};
	assign npad     = (params.width_sat > ndig_ext) ? (params.width_sat - ndig_ext) : 6'd0;

	// Produce a character whenever the output register is free
	assign take   = busy_q && (!ovalid_q || out_ready);
	assign last_c = (rem_q == 6'd1) || ((pad_q == 6'd0) && (dig_q == 5'd1));
	assign char_c = (pad_q != 6'd0) ? padch_q
		: i2a_pkg::digit_char(sh_q[TOP +: i2a_pkg::DIGIT_W], upper_q);

	// Counters and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			pad_q    <= '0;
			dig_q    <= '0;
			rem_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				pad_q  <= npad;
				dig_q  <= digs.ndig;
				rem_q  <= params.room;
			end else if (take) begin
				if (pad_q != 6'd0) begin
					pad_q <= pad_q - 1'b1;
				end else begin
					dig_q <= dig_q - 1'b1;
				end
				rem_q <= rem_q - 1'b1;
				if (last_c) begin
					busy_q <= 1'b0;
				end
			end
			if (take) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// Digit shift register and output payload
	always_ff @(posedge clk) begin
		if (start) begin
			sh_q    <= digs.digits;
			padch_q <= params.pad_char;
			upper_q <= params.upper;
		end else if (take && pad_q == 6'd0) begin
			sh_q <= {sh_q[TOP-1:0], {i2a_pkg::DIGIT_W{1'b0}}};
		end
		if (take) begin
			char_q <= char_c;
			last_q <= last_c;
		end
	end

	assign busy        = busy_q;
	assign out_valid   = ovalid_q;
	assign character   = char_q;
	assign last_of_run = last_q;

endmodule

@@ rtl/core/integer_to_ascii_padded_top.sv @@
// Padded integer-to-ASCII converter.
// Input channel (in_valid/in_ready): mode, value, zero_pad, width, room.
// Output channel (out_valid/out_ready): one character per transaction,
// last_of_run marks the final character of an input's run.
// One input transaction is handled at a time; in_ready is high only while idle.
// Decimal: double dabble, one value bit per cycle over all 64 bits, builds 20 BCD digits,
// then leading zeros are stripped one digit per cycle (up to 19 digits).
// Hex: nibbles load at once, then the same leading-zero strip (4 to 19 digits).
// Emission: one character per cycle while out_ready allows, from a digit shift
// register, up to 40 characters (width saturates at 40, capped by room).
// The first character follows the conversion and strip; room zero is taken with no output.
// The output register holds a character while out_ready is low; emission pauses
// and resumes with no loss. A new input is taken once the last character of the
// run sits in the output register, so conversion overlaps its delivery.
// Reset clears all control state; no output is valid after reset.
module integer_to_ascii_padded_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [63:0] value,
	input  logic        zero_pad,
	input  logic [5:0]  width,
	input  logic [5:0]  room,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  character,
	output logic        last_of_run
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]              state_q;
	i2a_pkg::emit_params_t   prm_q;
	i2a_pkg::emit_params_t   prm_c;
	i2a_pkg::digits_t        digs;
	logic                    accept;
	logic                    conv_start;
	logic                    conv_done;
	logic                    emit_start;
	logic                    emit_busy;

	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign conv_start = accept && (room != 6'd0);
	assign emit_start = (state_q == ST_CONV) && conv_done;

	// Settings for this transaction
	always_comb begin
		prm_c.pad_char  = zero_pad ? i2a_pkg::CHAR_ZERO : i2a_pkg::CHAR_SPACE;
		prm_c.upper     = (mode != i2a_pkg::MODE_DEC) && (mode != i2a_pkg::MODE_LOWER);
		prm_c.width_sat = (width > i2a_pkg::MAX_WIDTH) ? i2a_pkg::MAX_WIDTH : width;
		prm_c.room      = room;
	end

	always_ff @(posedge clk) begin
		if (conv_start) begin
			prm_q <= prm_c;
		end
	end

	// Top-level sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (conv_start) begin
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (conv_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!emit_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	i2a_conv u_conv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (conv_start),
		.value  (value),
		.hex    (mode != i2a_pkg::MODE_DEC),
		.done   (conv_done),
		.result (digs)
	);

	i2a_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (emit_start),
		.params      (prm_q),
		.digs        (digs),
		.busy        (emit_busy),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.character   (character),
		.last_of_run (last_of_run)
	);

endmodule
